/* rtl/podi_pkg.sv */
// Shared constants, state types and the arctangent table of the odometry integrator.
package podi_pkg;

	localparam int ANGLE_BITS_DEF    = 16;
	localparam int POSITION_BITS_DEF = 48;
	localparam int DELTA_BITS_DEF    = 24;

	localparam int CORDIC_STEPS = 16;
	localparam int STEP_W       = $clog2(CORDIC_STEPS);
	localparam int PHASE_W      = 32;
	localparam int PRE_SHIFT    = 12;
	localparam int GUARD_BITS   = 3;
	localparam int GAIN_BITS    = 16;
	localparam int GAIN_Q16     = 39797;
	localparam int ROUND_SHIFT  = PRE_SHIFT + 16;

	typedef enum logic [3:0] {
		C_IDLE  = 4'b0001,
		C_ITER  = 4'b0010,
		C_MUL_X = 4'b0100,
		C_MUL_Y = 4'b1000
	} cordic_state_t;

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_ROT   = 6'b000010,
		S_ACC_X = 6'b000100,
		S_ACC_Y = 6'b001000,
		S_ACC_Z = 6'b010000,
		S_OUT   = 6'b100000
	} core_state_t;

	// Arctangent of 2^-i in units of 2^32 per turn.
	function automatic logic signed [PHASE_W-1:0] atan_turn(input logic [STEP_W-1:0] idx);
		logic signed [PHASE_W-1:0] v;
		unique case (idx)
			4'd0:    v = 32'sh20000000;
			4'd1:    v = 32'sh12E4051D;
			4'd2:    v = 32'sh09FB385B;
			4'd3:    v = 32'sh051111D4;
			4'd4:    v = 32'sh028B0D43;
			4'd5:    v = 32'sh0145D7E1;
			4'd6:    v = 32'sh00A2F61E;
			4'd7:    v = 32'sh00517C55;
			4'd8:    v = 32'sh0028BE53;
			4'd9:    v = 32'sh00145F2E;
			4'd10:   v = 32'sh000A2F98;
			4'd11:   v = 32'sh000517CC;
			4'd12:   v = 32'sh00028BE6;
			4'd13:   v = 32'sh000145F3;
			4'd14:   v = 32'sh0000A2F9;
			4'd15:   v = 32'sh0000517C;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

/* rtl/podi_cordic.sv */
// Iterative CORDIC rotator with quadrant pre-turn and a shared gain multiplier.
module podi_cordic #(
	parameter int ANGLE_BITS = podi_pkg::ANGLE_BITS_DEF,
	parameter int DELTA_BITS = podi_pkg::DELTA_BITS_DEF,
	localparam int CW = DELTA_BITS + podi_pkg::PRE_SHIFT + podi_pkg::GUARD_BITS,
	localparam int PW = CW + podi_pkg::GAIN_BITS + 1,
	localparam int RW = PW - podi_pkg::ROUND_SHIFT
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic signed [DELTA_BITS-1:0] delta_x,
	input  logic signed [DELTA_BITS-1:0] delta_y,
	input  logic signed [ANGLE_BITS-1:0] heading,
	output logic                         done,
	output logic signed [RW-1:0]         rot_x,
	output logic signed [RW-1:0]         rot_y
);

	localparam int PH = podi_pkg::PHASE_W;
	localparam logic [PH-1:0] QUARTER_HALF = PH'(1) << (PH - 3);
	localparam logic signed [PW-1:0] ROUND_ADD = PW'(1) << (podi_pkg::ROUND_SHIFT - 1);
	localparam logic [podi_pkg::STEP_W-1:0] LAST_STEP =
		podi_pkg::STEP_W'(podi_pkg::CORDIC_STEPS - 1);

	podi_pkg::cordic_state_t state_q;
	logic [podi_pkg::STEP_W-1:0] iter_q;
	logic signed [CW-1:0] x_q, y_q;
	logic signed [PH-1:0] z_q;
	logic signed [RW-1:0] rx_q, ry_q;

	logic [PH-1:0] phase_w, shifted_w;
	logic [1:0] quad_w;
	logic signed [PH-1:0] z0_w, atan_w;
	logic signed [CW-1:0] dx_w, dy_w, x0_w, y0_w, xs_w, ys_w, mul_a_w;
	logic signed [podi_pkg::GAIN_BITS:0] gain_w;
	logic signed [PW-1:0] prod_w, round_w;
	logic signed [RW-1:0] res_w;

	// The heading is moved by an eighth turn so the top two bits pick the nearest quadrant.
	assign phase_w   = {heading, {(PH - ANGLE_BITS){1'b0}}};
	assign shifted_w = phase_w + QUARTER_HALF;
	assign quad_w    = shifted_w[PH-1:PH-2];
	assign z0_w      = $signed({2'b00, shifted_w[PH-3:0]}) - $signed(QUARTER_HALF);

	assign dx_w = CW'(delta_x) <<< podi_pkg::PRE_SHIFT;
	assign dy_w = CW'(delta_y) <<< podi_pkg::PRE_SHIFT;

	always_comb begin
		case (quad_w)
			2'd1: begin
				x0_w = -dy_w;
				y0_w = dx_w;
			end
			2'd2: begin
				x0_w = -dx_w;
				y0_w = -dy_w;
			end
			2'd3: begin
				x0_w = dy_w;
				y0_w = -dx_w;
			end
			default: begin
				x0_w = dx_w;
				y0_w = dy_w;
			end
		endcase
	end

	assign xs_w   = x_q >>> iter_q;
	assign ys_w   = y_q >>> iter_q;
	assign atan_w = podi_pkg::atan_turn(iter_q);

	assign gain_w  = $signed({1'b0, podi_pkg::GAIN_BITS'(podi_pkg::GAIN_Q16)});
	assign mul_a_w = (state_q == podi_pkg::C_MUL_X) ? x_q : y_q;
	assign prod_w  = PW'(mul_a_w) * PW'(gain_w);
	assign round_w = prod_w + ROUND_ADD;
	assign res_w   = $signed(round_w[PW-1:podi_pkg::ROUND_SHIFT]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= podi_pkg::C_IDLE;
			iter_q  <= '0;
		end else begin
			unique case (state_q)
				podi_pkg::C_IDLE: begin
					iter_q <= '0;
					if (start) begin
						state_q <= podi_pkg::C_ITER;
					end
				end
				podi_pkg::C_ITER: begin
					iter_q <= iter_q + 1'b1;
					if (iter_q == LAST_STEP) begin
						state_q <= podi_pkg::C_MUL_X;
					end
				end
				podi_pkg::C_MUL_X: state_q <= podi_pkg::C_MUL_Y;
				podi_pkg::C_MUL_Y: state_q <= podi_pkg::C_IDLE;
				default:           state_q <= podi_pkg::C_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == podi_pkg::C_IDLE && start) begin
			x_q <= x0_w;
			y_q <= y0_w;
			z_q <= z0_w;
		end else if (state_q == podi_pkg::C_ITER) begin
			if (!z_q[PH-1]) begin
				x_q <= x_q - ys_w;
				y_q <= y_q + xs_w;
				z_q <= z_q - atan_w;
			end else begin
				x_q <= x_q + ys_w;
				y_q <= y_q - xs_w;
				z_q <= z_q + atan_w;
			end
		end
		if (state_q == podi_pkg::C_MUL_X) begin
			rx_q <= res_w;
		end
		if (state_q == podi_pkg::C_MUL_Y) begin
			ry_q <= res_w;
		end
	end

	assign done  = (state_q == podi_pkg::C_MUL_Y);
	assign rot_x = rx_q;
	assign rot_y = ry_q;

endmodule

/* rtl/planar_odometry_integrator_core.sv */
// Top level: handshake, sequencer and shared saturating accumulator of the odometry integrator.
// An accumulating word gives its result after the 16 CORDIC micro-rotations of the shared
// shift-add unit, the two gain multiplies and three accumulator updates; a clear or an invalid
// word gives it in the cycle after acceptance. The next word is taken the cycle after the
// result is taken, so a new word waits until the result of the last one has been taken.
// Reset is asynchronous and zeroes all three positions.
module planar_odometry_integrator_core #(
	parameter int ANGLE_BITS    = podi_pkg::ANGLE_BITS_DEF,
	parameter int POSITION_BITS = podi_pkg::POSITION_BITS_DEF,
	parameter int DELTA_BITS    = podi_pkg::DELTA_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic                            clear_origin,
	input  logic                            displacement_valid,
	input  logic                            yaw_valid,
	input  logic signed [DELTA_BITS-1:0]    delta_x,
	input  logic signed [DELTA_BITS-1:0]    delta_y,
	input  logic signed [DELTA_BITS-1:0]    delta_z,
	input  logic signed [ANGLE_BITS-1:0]    heading,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic signed [POSITION_BITS-1:0] world_x,
	output logic signed [POSITION_BITS-1:0] world_y,
	output logic signed [POSITION_BITS-1:0] world_z,
	output logic                            updated
);

	localparam int CW = DELTA_BITS + podi_pkg::PRE_SHIFT + podi_pkg::GUARD_BITS;
	localparam int RW = CW + podi_pkg::GAIN_BITS + 1 - podi_pkg::ROUND_SHIFT;
	localparam int SW = ((POSITION_BITS > RW) ? POSITION_BITS : RW) + 1;
	localparam int HW = SW - POSITION_BITS + 1;
	localparam logic signed [POSITION_BITS-1:0] POS_MAX = {1'b0, {(POSITION_BITS-1){1'b1}}};
	localparam logic signed [POSITION_BITS-1:0] POS_MIN = {1'b1, {(POSITION_BITS-1){1'b0}}};

	podi_pkg::core_state_t state_q;
	logic signed [POSITION_BITS-1:0] acc_x_q, acc_y_q, acc_z_q;
	logic signed [DELTA_BITS-1:0] dz_q;
	logic updated_q;

	logic in_accept, do_update, rot_done;
	logic signed [RW-1:0] rot_x, rot_y;
	logic signed [POSITION_BITS-1:0] acc_sel_w, sat_w;
	logic signed [SW-1:0] add_sel_w, sum_w;

	assign in_stall  = (state_q != podi_pkg::S_IDLE);
	assign in_accept = in_valid && !in_stall;
	assign do_update = !clear_origin && displacement_valid && yaw_valid;

	podi_cordic #(
		.ANGLE_BITS(ANGLE_BITS),
		.DELTA_BITS(DELTA_BITS)
	) u_cordic (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (in_accept && do_update),
		.delta_x (delta_x),
		.delta_y (delta_y),
		.heading (heading),
		.done    (rot_done),
		.rot_x   (rot_x),
		.rot_y   (rot_y)
	);

	// One saturating adder serves all three accumulators in turn.
	always_comb begin
		unique case (state_q)
			podi_pkg::S_ACC_X: begin
				acc_sel_w = acc_x_q;
				add_sel_w = SW'(rot_x);
			end
			podi_pkg::S_ACC_Y: begin
				acc_sel_w = acc_y_q;
				add_sel_w = SW'(rot_y);
			end
			default: begin
				acc_sel_w = acc_z_q;
				add_sel_w = SW'(dz_q);
			end
		endcase
	end

	assign sum_w = SW'(acc_sel_w) + add_sel_w;

	always_comb begin
		if (sum_w[SW-1:POSITION_BITS-1] == {HW{sum_w[SW-1]}}) begin
			sat_w = sum_w[POSITION_BITS-1:0];
		end else if (sum_w[SW-1]) begin
			sat_w = POS_MIN;
		end else begin
			sat_w = POS_MAX;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= podi_pkg::S_IDLE;
			acc_x_q   <= '0;
			acc_y_q   <= '0;
			acc_z_q   <= '0;
			updated_q <= 1'b0;
		end else begin
			unique case (state_q)
				podi_pkg::S_IDLE: begin
					if (in_accept) begin
						updated_q <= do_update;
						if (clear_origin) begin
							acc_x_q <= '0;
							acc_y_q <= '0;
							acc_z_q <= '0;
						end
						state_q <= do_update ? podi_pkg::S_ROT : podi_pkg::S_OUT;
					end
				end
				podi_pkg::S_ROT: begin
					if (rot_done) begin
						state_q <= podi_pkg::S_ACC_X;
					end
				end
				podi_pkg::S_ACC_X: begin
					acc_x_q <= sat_w;
					state_q <= podi_pkg::S_ACC_Y;
				end
				podi_pkg::S_ACC_Y: begin
					acc_y_q <= sat_w;
					state_q <= podi_pkg::S_ACC_Z;
				end
				podi_pkg::S_ACC_Z: begin
					acc_z_q <= sat_w;
					state_q <= podi_pkg::S_OUT;
				end
				podi_pkg::S_OUT: begin
					if (!out_stall) begin
						state_q <= podi_pkg::S_IDLE;
					end
				end
				default: state_q <= podi_pkg::S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			dz_q <= delta_z;
		end
	end

	assign out_valid = (state_q == podi_pkg::S_OUT);
	assign world_x   = acc_x_q;
	assign world_y   = acc_y_q;
	assign world_z   = acc_z_q;
	assign updated   = updated_q;

endmodule

/* sim/tb_planar_odometry_integrator_core.sv */
// Self-checking testbench of the planar odometry integrator against a local integrator model.
module tb_planar_odometry_integrator_core;

	localparam int AW = podi_pkg::ANGLE_BITS_DEF;
	localparam int PW = podi_pkg::POSITION_BITS_DEF;
	localparam int DW = podi_pkg::DELTA_BITS_DEF;

	localparam int ROT_STEPS    = 16;
	localparam int ROT_PRESCALE = 12;
	localparam longint ROT_GAIN = 39797;
	localparam longint POS_HI   = (64'sd1 <<< (PW - 1)) - 1;
	localparam longint POS_LO   = -POS_HI - 1;
	localparam longint ARCTAN_STEP [ROT_STEPS] = '{
		64'sh20000000, 64'sh12E4051D, 64'sh09FB385B, 64'sh051111D4,
		64'sh028B0D43, 64'sh0145D7E1, 64'sh00A2F61E, 64'sh00517C55,
		64'sh0028BE53, 64'sh00145F2E, 64'sh000A2F98, 64'sh000517CC,
		64'sh00028BE6, 64'sh000145F3, 64'sh0000A2F9, 64'sh0000517C
	};

	localparam logic signed [DW-1:0] DELTA_MAX = {1'b0, {(DW - 1){1'b1}}};
	localparam logic signed [DW-1:0] DELTA_MIN = {1'b1, {(DW - 1){1'b0}}};

	localparam int RANDOM_WORDS   = 900;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int SETTLE_CYCLES  = 40;

	typedef struct packed {
		logic                 clear;
		logic                 dvalid;
		logic                 yvalid;
		logic signed [DW-1:0] dx;
		logic signed [DW-1:0] dy;
		logic signed [DW-1:0] dz;
		logic signed [AW-1:0] head;
		logic                 drain_first;
	} odo_word_t;

	typedef struct packed {
		logic signed [PW-1:0] x;
		logic signed [PW-1:0] y;
		logic signed [PW-1:0] z;
		logic                 upd;
	} odo_pose_t;

	logic                 clk;
	logic                 arst_n             = 1'b0;
	logic                 in_valid           = 1'b0;
	logic                 in_stall;
	logic                 clear_origin       = 1'b0;
	logic                 displacement_valid = 1'b0;
	logic                 yaw_valid          = 1'b0;
	logic signed [DW-1:0] delta_x            = '0;
	logic signed [DW-1:0] delta_y            = '0;
	logic signed [DW-1:0] delta_z            = '0;
	logic signed [AW-1:0] heading            = '0;
	logic                 out_valid;
	logic                 out_stall          = 1'b0;
	logic signed [PW-1:0] world_x;
	logic signed [PW-1:0] world_y;
	logic signed [PW-1:0] world_z;
	logic                 updated;

	odo_word_t   word_queue[$];
	odo_pose_t   expected_poses[$];
	longint      pos_x, pos_y, pos_z;
	bit          word_taken;
	int unsigned send_gap, stall_left;
	int unsigned words_sent, cycle_no, quiet_cycles;
	int unsigned err_count, n_accum, n_clear, n_idle, n_checked;

	planar_odometry_integrator_core u_dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (in_valid),
		.in_stall          (in_stall),
		.clear_origin      (clear_origin),
		.displacement_valid(displacement_valid),
		.yaw_valid         (yaw_valid),
		.delta_x           (delta_x),
		.delta_y           (delta_y),
		.delta_z           (delta_z),
		.heading           (heading),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.world_x           (world_x),
		.world_y           (world_y),
		.world_z           (world_z),
		.updated           (updated)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Turn the chassis vector into the world frame: an exact quarter turn first, then
	// shift-add micro-rotations over the residual angle and removal of their gain.
	function automatic void rotate_to_world(input longint dx, input longint dy,
			input logic [AW-1:0] head, output longint wx, output longint wy);
		logic [31:0] phase;
		logic [31:0] shifted;
		longint      x, y, z, t, xs, ys;
		phase   = {head, {(32 - AW){1'b0}}};
		shifted = phase + 32'h2000_0000;
		z = longint'({2'b00, shifted[29:0]}) - 64'sh2000_0000;
		x = dx <<< ROT_PRESCALE;
		y = dy <<< ROT_PRESCALE;
		case (shifted[31:30])
			2'd1: begin
				t = x; x = -y; y = t;
			end
			2'd2: begin
				x = -x; y = -y;
			end
			2'd3: begin
				t = x; x = y; y = -t;
			end
			default: ;
		endcase
		for (int i = 0; i < ROT_STEPS; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (z >= 0) begin
				x = x - ys; y = y + xs; z = z - ARCTAN_STEP[i];
			end else begin
				x = x + ys; y = y - xs; z = z + ARCTAN_STEP[i];
			end
		end
		wx = (x * ROT_GAIN + (64'sd1 <<< (ROT_PRESCALE + 15))) >>> (ROT_PRESCALE + 16);
		wy = (y * ROT_GAIN + (64'sd1 <<< (ROT_PRESCALE + 15))) >>> (ROT_PRESCALE + 16);
	endfunction

	function automatic longint clamp_pos(input longint a, input longint b);
		longint s;
		s = a + b;
		if (s > POS_HI)
			return POS_HI;
		if (s < POS_LO)
			return POS_LO;
		return s;
	endfunction

	// Advance the local position state by one accepted word and give the pose it reports.
	task automatic integrate_word(input odo_word_t w, output odo_pose_t pose);
		longint wx, wy;
		pose.upd = 1'b0;
		if (w.clear) begin
			pos_x = 0;
			pos_y = 0;
			pos_z = 0;
		end else if (w.dvalid && w.yvalid) begin
			rotate_to_world(longint'(w.dx), longint'(w.dy), w.head, wx, wy);
			pos_x = clamp_pos(pos_x, wx);
			pos_y = clamp_pos(pos_y, wy);
			pos_z = clamp_pos(pos_z, longint'(w.dz));
			pose.upd = 1'b1;
		end
		pose.x = pos_x[PW-1:0];
		pose.y = pos_y[PW-1:0];
		pose.z = pos_z[PW-1:0];
	endtask

	function automatic int unsigned pick_idle(input bit calm);
		int unsigned r;
		r = $urandom_range(0, 99);
		if (calm || r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 4);
		if (r < 97)
			return $urandom_range(5, 30);
		return $urandom_range(31, 90);
	endfunction

	function automatic logic signed [DW-1:0] rand_delta();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return DW'($urandom());
		if (r < 80) begin
			case ($urandom_range(0, 4))
				0: return DELTA_MAX;
				1: return DELTA_MIN;
				2: return '0;
				3: return DW'(1);
				default: return DW'(-1);
			endcase
		end
		return DW'($signed($urandom_range(0, 8192)) - 4096);
	endfunction

	// Headings near the octant boundaries stress the quarter-turn selection.
	function automatic logic signed [AW-1:0] rand_heading();
		logic [AW-1:0] base;
		if ($urandom_range(0, 99) < 75)
			return AW'($urandom());
		base = AW'($urandom_range(0, 7)) << (AW - 3);
		return base + AW'($signed($urandom_range(0, 4)) - 2);
	endfunction

	task automatic add_word(input logic clr, input logic dv, input logic yv,
			input logic signed [DW-1:0] dx, input logic signed [DW-1:0] dy,
			input logic signed [DW-1:0] dz, input logic signed [AW-1:0] head,
			input logic drain);
		odo_word_t w;
		w.clear       = clr;
		w.dvalid      = dv;
		w.yvalid      = yv;
		w.dx          = dx;
		w.dy          = dy;
		w.dz          = dz;
		w.head        = head;
		w.drain_first = drain;
		word_queue.push_back(w);
	endtask

	// Sender: a new word goes out at the falling edge after the previous one was taken,
	// possibly after an idle gap.
	always @(negedge clk) begin : drive_words
		odo_word_t nxt;
		if (arst_n && (!in_valid || word_taken)) begin
			word_taken = 1'b0;
			if (send_gap > 0) begin
				send_gap--;
				in_valid <= 1'b0;
			end else if (word_queue.size() != 0 &&
					!(word_queue[0].drain_first && expected_poses.size() != 0)) begin
				nxt = word_queue.pop_front();
				in_valid           <= 1'b1;
				clear_origin       <= nxt.clear;
				displacement_valid <= nxt.dvalid;
				yaw_valid          <= nxt.yvalid;
				delta_x            <= nxt.dx;
				delta_y            <= nxt.dy;
				delta_z            <= nxt.dz;
				heading            <= nxt.head;
				send_gap = pick_idle((words_sent / 64) % 5 == 4);
				words_sent++;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin : drive_stall
		int unsigned n;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			out_stall <= 1'b1;
		end else begin
			n = pick_idle((cycle_no / 1500) % 4 == 1);
			if (n > 0) begin
				stall_left = n - 1;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin : watch_ports
		odo_word_t w;
		odo_pose_t want;
		bit        moved;
		if (arst_n) begin
			moved = 1'b0;
			cycle_no++;
			if (in_valid && !in_stall) begin
				w = '{clear_origin, displacement_valid, yaw_valid, delta_x, delta_y, delta_z,
					heading, 1'b0};
				integrate_word(w, want);
				expected_poses.push_back(want);
				if (w.clear)
					n_clear++;
				else if (want.upd)
					n_accum++;
				else
					n_idle++;
				word_taken = 1'b1;
				moved = 1'b1;
			end
			if (out_valid && !out_stall) begin
				moved = 1'b1;
				if (expected_poses.size() == 0) begin
					$error("result word with no pending expectation: x=%0d y=%0d z=%0d",
						world_x, world_y, world_z);
					err_count++;
				end else begin
					want = expected_poses.pop_front();
					n_checked++;
					if (world_x !== want.x) begin
						$error("world_x: expected %0d, got %0d", want.x, world_x);
						err_count++;
					end
					if (world_y !== want.y) begin
						$error("world_y: expected %0d, got %0d", want.y, world_y);
						err_count++;
					end
					if (world_z !== want.z) begin
						$error("world_z: expected %0d, got %0d", want.z, world_z);
						err_count++;
					end
					if (updated !== want.upd) begin
						$error("updated: expected %0b, got %0b", want.upd, updated);
						err_count++;
					end
				end
			end
			quiet_cycles = moved ? 0 : quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no handshake for %0d cycles", quiet_cycles);
				$display("FAILURE");
				$finish;
			end
		end
	end

	initial begin : main_flow
		int unsigned r, counted;
		bit          clr, dv, yv;
		pos_x = 0;
		pos_y = 0;
		pos_z = 0;

		// Directed words: flag combinations, field extremes and octant boundaries.
		add_word(1'b0, 1'b0, 1'b0, 24'sh123456, -24'sd5, 24'sd7, 16'sh0100, 1'b0);
		add_word(1'b0, 1'b1, 1'b0, DELTA_MAX, DELTA_MAX, DELTA_MAX, 16'sh0000, 1'b0);
		add_word(1'b0, 1'b0, 1'b1, DELTA_MIN, DELTA_MIN, DELTA_MIN, 16'sh4000, 1'b0);
		add_word(1'b0, 1'b1, 1'b1, DELTA_MAX, '0, DELTA_MAX, 16'sh0000, 1'b0);
		add_word(1'b0, 1'b1, 1'b1, DELTA_MIN, DELTA_MAX, DELTA_MIN, 16'sh4000, 1'b0);
		add_word(1'b0, 1'b1, 1'b1, DELTA_MAX, DELTA_MIN, DELTA_MAX, 16'sh8000, 1'b0);
		add_word(1'b0, 1'b1, 1'b1, 24'sd1000000, -24'sd2000000, 24'sd12345, 16'shC000, 1'b0);
		add_word(1'b0, 1'b1, 1'b1, DELTA_MAX, DELTA_MAX, 24'sd1, 16'sh2000, 1'b0);
		add_word(1'b0, 1'b1, 1'b1, DELTA_MIN, DELTA_MIN, -24'sd1, 16'sh1FFF, 1'b0);
		add_word(1'b0, 1'b1, 1'b1, 24'sd65536, 24'sd65536, '0, 16'sh7FFF, 1'b0);
		add_word(1'b0, 1'b1, 1'b1, -24'sd65536, 24'sd32768, '0, 16'shFFFF, 1'b0);
		add_word(1'b0, 1'b1, 1'b1, 24'sd300000, -24'sd300000, 24'sd5, 16'sh6000, 1'b0);
		add_word(1'b0, 1'b1, 1'b1, -24'sd300000, 24'sd300000, -24'sd5, 16'shE000, 1'b0);
		add_word(1'b0, 1'b1, 1'b1, '0, '0, '0, 16'sh1234, 1'b0);
		add_word(1'b0, 1'b1, 1'b1, 24'sd1, -24'sd1, '0, 16'sh5555, 1'b0);
		add_word(1'b1, 1'b1, 1'b1, DELTA_MAX, DELTA_MAX, DELTA_MAX, 16'sh2000, 1'b1);
		add_word(1'b0, 1'b1, 1'b1, DELTA_MAX, DELTA_MIN, DELTA_MIN, 16'sh9FFF, 1'b0);
		add_word(1'b1, 1'b0, 1'b0, '0, '0, '0, 16'sh0000, 1'b0);
		add_word(1'b1, 1'b0, 1'b1, 24'sd42, 24'sd42, 24'sd42, 16'sh2001, 1'b0);
		add_word(1'b0, 1'b1, 1'b1, DELTA_MIN, '0, DELTA_MAX, 16'shA000, 1'b0);

		// Random words, mostly accumulating ones; occasionally the sender waits for a drain.
		counted = 0;
		while (counted < RANDOM_WORDS) begin
			r = $urandom_range(0, 99);
			if (r < 80) begin
				clr = 1'b0; dv = 1'b1; yv = 1'b1;
			end else if (r < 87) begin
				clr = 1'b1; dv = 1'($urandom()); yv = 1'($urandom());
			end else begin
				clr = 1'b0; dv = 1'($urandom()); yv = 1'($urandom());
			end
			add_word(clr, dv, yv, rand_delta(), rand_delta(), rand_delta(), rand_heading(),
				$urandom_range(0, 99) == 0);
			counted++;
		end

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (word_queue.size() != 0 || in_valid || expected_poses.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("covered %0d accumulating, %0d clearing and %0d non-updating words",
			n_accum, n_clear, n_idle);
		$display("%0d result words compared over %0d cycles, %0d mismatches",
			n_checked, cycle_no, err_count);
		if (err_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

/* planar_odometry_integrator_core.f */
rtl/podi_pkg.sv
rtl/podi_cordic.sv
rtl/planar_odometry_integrator_core.sv
sim/tb_planar_odometry_integrator_core.sv
